// ===== rtl/core/dlld_pkg.sv =====
// dlld_pkg: shared types, codes and helpers of the linked list deque
// no dependencies; imported by the controller, the top level and the checker
package dlld_pkg;

    // default node pool size
    localparam int CAPACITY_DEFAULT = 256;

    // element payload: tag at the top bit, value below
    localparam int VALUE_W = 32;
    localparam int PAY_W   = VALUE_W + 1;

    // request codes
    typedef enum logic [2:0] {
        REQ_PUSH_HEAD = 3'd0,
        REQ_PUSH_TAIL = 3'd1,
        REQ_POP_HEAD  = 3'd2,
        REQ_POP_TAIL  = 3'd3,
        REQ_DELETE    = 3'd4,
        REQ_SEARCH    = 3'd5,
        REQ_CLEAR     = 3'd6
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_LINK,
        S_WALK,
        S_UNLINK,
        S_RELEASE,
        S_DONE
    } state_t;

    // finished result handed from the controller to the output register
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic                is_char;
        logic [VALUE_W-1:0]  value;
    } result_t;

    // tagged element as stored in the node pool; a character keeps its low 8 bits
    function automatic logic [PAY_W-1:0] make_key(input logic is_char,
                                                  input logic [VALUE_W-1:0] val);
        logic [PAY_W-1:0] key;
        if (is_char)
        begin
            key = {1'b1, {(VALUE_W-8){1'b0}}, val[7:0]};
        end
        else
        begin
            key = {1'b0, val};
        end
        return key;
    endfunction

endpackage

// ===== rtl/core/dlld_ram.sv =====
// dlld_ram: single write port, single read port synchronous memory
// read data registered, held while no read is issued; no package use
module dlld_ram #(
    parameter int  WIDTH = 9,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dlld_ctrl.sv =====
// dlld_ctrl: request sequencer with list pointers, free chain head and walk
// depends on dlld_pkg; drives the three node memories instantiated at the top
module dlld_ctrl #(
    parameter int  CAPACITY = dlld_pkg::CAPACITY_DEFAULT,
    localparam int IW       = $clog2(CAPACITY + 1),
    localparam int AW       = $clog2(CAPACITY)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request side
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             req_type,
    input  logic                   value_is_char,
    input  logic [31:0]            value,
    // result side
    output dlld_pkg::result_t      result,
    output logic [IW-1:0]          count,
    input  logic                   slot_free,
    // node memories
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic [IW-1:0]          fwd_rd,
    input  logic [IW-1:0]          bwd_rd,
    input  logic [dlld_pkg::PAY_W-1:0] pay_rd,
    output logic                   fwd_we,
    output logic [AW-1:0]          fwd_waddr,
    output logic [IW-1:0]          fwd_wdata,
    output logic                   bwd_we,
    output logic [AW-1:0]          bwd_waddr,
    output logic [IW-1:0]          bwd_wdata,
    output logic                   pay_we,
    output logic [AW-1:0]          pay_waddr,
    output logic [dlld_pkg::PAY_W-1:0] pay_wdata
);

    import dlld_pkg::*;

    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    state_t             state_reg, state_next;
    logic [2:0]         req_reg, req_next;
    logic [PAY_W-1:0]   key_reg, key_next;
    logic [IW-1:0]      front_reg, front_next;
    logic [IW-1:0]      back_reg, back_next;
    logic [IW-1:0]      free_reg, free_next;
    logic [IW-1:0]      fill_reg, fill_next;
    logic [IW-1:0]      len_reg, len_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      steps_reg, steps_next;
    logic               virgin_reg, virgin_next;
    status_t            res_status_reg, res_status_next;
    logic               res_char_reg, res_char_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;

    // helper terms
    logic          list_empty;
    logic [IW-1:0] pop_node;
    logic [IW-1:0] unl_next;
    logic [IW-1:0] unl_prev;
    logic [IW-1:0] steps_inc;

    assign list_empty = (len_reg == '0) || (front_reg >= NIL);
    assign pop_node   = (req_reg == REQ_POP_HEAD) ? front_reg : back_reg;
    assign steps_inc  = steps_reg + IW'(1);

    // neighbors of the node being unlinked, ends forced to null
    assign unl_next = ((fwd_rd >= NIL) || (cur_reg == back_reg)) ? NIL : fwd_rd;
    assign unl_prev = ((bwd_rd >= NIL) || (cur_reg == front_reg)) ? NIL : bwd_rd;

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= NIL;
            back_reg   <= NIL;
            free_reg   <= '0;
            fill_reg   <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            free_reg   <= free_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        virgin_reg     <= virgin_next;
        res_status_reg <= res_status_next;
        res_char_reg   <= res_char_next;
        res_value_reg  <= res_value_next;
    end

    // next state, memory accesses and pointer updates
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        free_next       = free_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        virgin_next     = virgin_reg;
        res_status_next = res_status_reg;
        res_char_next   = res_char_reg;
        res_value_next  = res_value_reg;

        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        fwd_we    = 1'b0;
        fwd_waddr = '0;
        fwd_wdata = '0;
        bwd_we    = 1'b0;
        bwd_waddr = '0;
        bwd_wdata = '0;
        pay_we    = 1'b0;
        pay_waddr = '0;
        pay_wdata = '0;

        result.valid   = 1'b0;
        result.status  = res_status_reg;
        result.is_char = res_char_reg;
        result.value   = res_value_reg;

        unique case (state_reg)
            // take a new item
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = req_type;
                    key_next   = make_key(value_is_char, value);
                    state_next = S_DISPATCH;
                end
            end

            // check corner cases and issue the first read
            S_DISPATCH:
            begin
                res_status_next = STAT_OK;
                res_char_next   = 1'b0;
                res_value_next  = '0;
                state_next      = S_DONE;
                unique case (req_reg)
                    REQ_PUSH_HEAD, REQ_PUSH_TAIL:
                    begin
                        if ((free_reg >= NIL) || (len_reg >= NIL))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = free_reg[AW-1:0];
                            virgin_next = (free_reg == fill_reg);
                            state_next  = S_ALLOC;
                        end
                    end
                    REQ_POP_HEAD, REQ_POP_TAIL:
                    begin
                        if ((len_reg == '0) || (pop_node >= NIL))
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pop_node[AW-1:0];
                            cur_next   = pop_node;
                            state_next = S_UNLINK;
                        end
                    end
                    REQ_DELETE, REQ_SEARCH:
                    begin
                        if (list_empty)
                        begin
                            res_status_next = (req_reg == REQ_DELETE) ?
                                              STAT_EMPTY : STAT_NOT_FOUND;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = front_reg[AW-1:0];
                            cur_next   = front_reg;
                            steps_next = '0;
                            state_next = S_WALK;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        // splice the whole list onto the free chain
                        if ((len_reg != '0) && (front_reg < NIL) && (back_reg < NIL))
                        begin
                            fwd_we    = 1'b1;
                            fwd_waddr = back_reg[AW-1:0];
                            fwd_wdata = free_reg;
                            free_next = front_reg;
                        end
                        front_next = NIL;
                        back_next  = NIL;
                        len_next   = '0;
                    end
                    default:
                    begin
                        res_status_next = STAT_OK;
                    end
                endcase
            end

            // take the free node and write its payload and own links
            S_ALLOC:
            begin
                cur_next = free_reg;
                if (virgin_reg)
                begin
                    // untouched nodes chain to their successor
                    free_next = free_reg + IW'(1);
                    fill_next = fill_reg + IW'(1);
                end
                else
                begin
                    free_next = fwd_rd;
                end
                pay_we    = 1'b1;
                pay_waddr = free_reg[AW-1:0];
                pay_wdata = key_reg;
                fwd_we    = 1'b1;
                fwd_waddr = free_reg[AW-1:0];
                fwd_wdata = (!list_empty && (req_reg == REQ_PUSH_HEAD)) ? front_reg : NIL;
                bwd_we    = 1'b1;
                bwd_waddr = free_reg[AW-1:0];
                bwd_wdata = (!list_empty && (req_reg == REQ_PUSH_TAIL)) ? back_reg : NIL;
                state_next = S_LINK;
            end

            // hook the new node to its neighbor and move the end pointer
            S_LINK:
            begin
                if (list_empty)
                begin
                    front_next = cur_reg;
                    back_next  = cur_reg;
                end
                else if (req_reg == REQ_PUSH_HEAD)
                begin
                    bwd_we     = 1'b1;
                    bwd_waddr  = front_reg[AW-1:0];
                    bwd_wdata  = cur_reg;
                    front_next = cur_reg;
                end
                else
                begin
                    if (back_reg < NIL)
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = back_reg[AW-1:0];
                        fwd_wdata = cur_reg;
                    end
                    back_next = cur_reg;
                end
                len_next   = len_reg + IW'(1);
                state_next = S_DONE;
            end

            // compare one node per cycle, front to back
            S_WALK:
            begin
                if (pay_rd == key_reg)
                begin
                    res_status_next = STAT_OK;
                    state_next = (req_reg == REQ_DELETE) ? S_UNLINK : S_DONE;
                end
                else if ((fwd_rd >= NIL) || (steps_inc >= len_reg))
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = fwd_rd[AW-1:0];
                    cur_next   = fwd_rd;
                    steps_next = steps_inc;
                end
            end

            // bridge the neighbors of the node, read data still holds its links
            S_UNLINK:
            begin
                if ((req_reg == REQ_POP_HEAD) || (req_reg == REQ_POP_TAIL))
                begin
                    res_char_next  = pay_rd[PAY_W-1];
                    res_value_next = pay_rd[VALUE_W-1:0];
                end
                if (unl_prev < NIL)
                begin
                    fwd_we    = 1'b1;
                    fwd_waddr = unl_prev[AW-1:0];
                    fwd_wdata = unl_next;
                end
                else
                begin
                    front_next = unl_next;
                end
                if (unl_next < NIL)
                begin
                    bwd_we    = 1'b1;
                    bwd_waddr = unl_next[AW-1:0];
                    bwd_wdata = unl_prev;
                end
                else
                begin
                    back_next = unl_prev;
                end
                state_next = S_RELEASE;
            end

            // push the node onto the free chain
            S_RELEASE:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = cur_reg[AW-1:0];
                fwd_wdata = free_reg;
                free_next = cur_reg;
                if (len_reg != '0)
                begin
                    len_next = len_reg - IW'(1);
                end
                state_next = S_DONE;
            end

            // hand the result over once the output register has room
            S_DONE:
            begin
                result.valid = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign count = len_reg;

endmodule

// ===== rtl/core/doubly_linked_list_deque_top.sv =====
// doubly_linked_list_deque_top: deque over a node pool, output register
// depends on dlld_pkg, dlld_ram (three node memories) and dlld_ctrl
//
// Usage: one request item in (req_type, value_is_char, value) gives one
// result item out (status, result_is_char, result_value, element_count).
// Both channels are valid/ready; an item moves when valid and ready are high.
// One request is worked at a time. Search and delete walk the list from
// the front and compare at most element_count nodes; a delete that finds
// a match then unlinks that node. The walk reads one node per cycle
// through the single read port of the node memories.
// in_ready rises again in the cycle after the result is passed to the output
// register, so a new item is taken while an earlier result still waits.
// A stalled receiver holds the output register; the controller then waits
// with its finished result and accepts no new item.
// Reset empties the list at once; the free chain over untouched nodes is
// tracked by a fill mark, so no clearing pass runs after reset.
module doubly_linked_list_deque_top #(
    parameter int  CAPACITY = dlld_pkg::CAPACITY_DEFAULT,
    localparam int IW       = $clog2(CAPACITY + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     req_type,
    input  logic           value_is_char,
    input  logic [31:0]    value,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     status,
    output logic           result_is_char,
    output logic [31:0]    result_value,
    output logic [IW-1:0]  element_count
);

    import dlld_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    result_t            ctrl_result;
    logic [IW-1:0]      ctrl_count;
    logic               slot_free;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [IW-1:0]      fwd_rd, bwd_rd;
    logic [PAY_W-1:0]   pay_rd;
    logic               fwd_we, bwd_we, pay_we;
    logic [AW-1:0]      fwd_waddr, bwd_waddr, pay_waddr;
    logic [IW-1:0]      fwd_wdata, bwd_wdata;
    logic [PAY_W-1:0]   pay_wdata;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic               char_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [IW-1:0]      count_reg;

    // request sequencer
    dlld_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .value_is_char (value_is_char),
        .value         (value),
        .result        (ctrl_result),
        .count         (ctrl_count),
        .slot_free     (slot_free),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .fwd_rd        (fwd_rd),
        .bwd_rd        (bwd_rd),
        .pay_rd        (pay_rd),
        .fwd_we        (fwd_we),
        .fwd_waddr     (fwd_waddr),
        .fwd_wdata     (fwd_wdata),
        .bwd_we        (bwd_we),
        .bwd_waddr     (bwd_waddr),
        .bwd_wdata     (bwd_wdata),
        .pay_we        (pay_we),
        .pay_waddr     (pay_waddr),
        .pay_wdata     (pay_wdata)
    );

    // forward links, also the free chain
    dlld_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (fwd_rd)
    );

    // backward links
    dlld_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (bwd_rd)
    );

    // tagged element payloads
    dlld_ram #(.WIDTH(PAY_W), .DEPTH(CAPACITY)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (pay_rd)
    );

    // output register
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= ctrl_result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && ctrl_result.valid)
        begin
            status_reg <= ctrl_result.status;
            char_reg   <= ctrl_result.is_char;
            value_reg  <= ctrl_result.value;
            count_reg  <= ctrl_count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_is_char = char_reg;
    assign result_value   = value_reg;
    assign element_count  = count_reg;

endmodule

// ===== rtl/core/dlld_checker.sv =====
// dlld_checker: port-level assertions for the deque top level
// depends on dlld_pkg; attached to doubly_linked_list_deque_top by bind below
module dlld_checker #(
    parameter int  CAPACITY = dlld_pkg::CAPACITY_DEFAULT,
    localparam int IW       = $clog2(CAPACITY + 1)
) (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input logic [1:0]     status,
    input logic           result_is_char,
    input logic [31:0]    result_value,
    input logic [IW-1:0]  element_count
);

    import dlld_pkg::*;

    localparam logic [IW-1:0] FULL_COUNT = IW'(CAPACITY);

    // a full pool is reported only when every node is in the list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |-> (element_count == FULL_COUNT))
        else $error("full status with free nodes left");

    // an empty report leaves the list empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EMPTY) |-> (element_count == '0))
        else $error("empty status with elements in list");

    // failed requests carry no element
    a_fail_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> !result_is_char && (result_value == '0))
        else $error("failed request returned an element");

    // a popped character has no bits above its low byte
    a_char_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_is_char |-> (result_value[31:8] == '0))
        else $error("character result wider than 8 bits");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(result_value) && $stable(element_count))
        else $error("result changed while stalled");

endmodule

bind doubly_linked_list_deque_top dlld_checker #(.CAPACITY(CAPACITY)) u_dlld_checker (.*);

// ===== test/tb_doubly_linked_list_deque_top.sv =====
// tb_doubly_linked_list_deque_top: self-checking bench for the linked list deque
// depends on dlld_pkg and doubly_linked_list_deque_top; checks each result against
// a typed directed row or an in-bench model of the node pool, free chain and list links
module tb_doubly_linked_list_deque_top;

    import dlld_pkg::*;

    localparam int POOL_SIZE      = CAPACITY_DEFAULT;
    localparam int IDX_W          = $clog2(POOL_SIZE + 1);
    localparam int ADDR_W         = $clog2(POOL_SIZE);
    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_SIZE);

    // request code with no operation behind it
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS   = 825;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        status_t           status;
        logic              is_char;
        logic [31:0]       value;
        logic [IDX_W-1:0]  count;
    } deque_result_t;

    typedef struct packed {
        logic [2:0]     req;
        logic           is_char;
        logic [31:0]    value;
        logic           typed;
        deque_result_t  want;
    } deque_row_t;

    typedef enum int {
        MODE_MIX,
        MODE_GROW,
        MODE_FULL,
        MODE_SHRINK
    } stream_mode_t;

    localparam deque_result_t NO_CHECK = '0;

    // directed rows: empty list cases, extremes, tag matching, duplicates
    localparam deque_row_t DIRECTED [25] = '{
        '{REQ_POP_HEAD,  1'b0, 32'h0000_0000, 1'b1, '{STAT_EMPTY,     1'b0, 32'h0, 9'd0}},
        '{REQ_POP_TAIL,  1'b1, 32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY,     1'b0, 32'h0, 9'd0}},
        '{REQ_DELETE,    1'b0, 32'h0000_0000, 1'b1, '{STAT_EMPTY,     1'b0, 32'h0, 9'd0}},
        '{REQ_SEARCH,    1'b0, 32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 1'b0, 32'h0, 9'd0}},
        '{REQ_CLEAR,     1'b0, 32'h0000_0000, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd0}},
        '{REQ_UNUSED,    1'b0, 32'h0000_0000, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd0}},
        '{REQ_PUSH_HEAD, 1'b0, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd1}},
        '{REQ_PUSH_TAIL, 1'b0, 32'h8000_0000, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd2}},
        '{REQ_PUSH_HEAD, 1'b1, 32'hABCD_EF41, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd3}},
        '{REQ_PUSH_TAIL, 1'b1, 32'h0000_00FF, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd4}},
        '{REQ_SEARCH,    1'b0, 32'h0000_0041, 1'b0, NO_CHECK},
        '{REQ_SEARCH,    1'b1, 32'h1234_5641, 1'b0, NO_CHECK},
        '{REQ_PUSH_TAIL, 1'b0, 32'h7FFF_FFFF, 1'b0, NO_CHECK},
        '{REQ_DELETE,    1'b0, 32'h7FFF_FFFF, 1'b0, NO_CHECK},
        '{REQ_DELETE,    1'b0, 32'h0000_0005, 1'b0, NO_CHECK},
        '{REQ_POP_HEAD,  1'b0, 32'h0000_0000, 1'b0, NO_CHECK},
        '{REQ_POP_TAIL,  1'b0, 32'h0000_0000, 1'b0, NO_CHECK},
        '{REQ_UNUSED,    1'b1, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
        '{REQ_POP_TAIL,  1'b1, 32'h0000_0000, 1'b0, NO_CHECK},
        '{REQ_CLEAR,     1'b0, 32'h0000_0000, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd0}},
        '{REQ_PUSH_HEAD, 1'b0, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd1}},
        '{REQ_POP_TAIL,  1'b0, 32'h0000_0000, 1'b1, '{STAT_OK,   1'b0, 32'hFFFF_FFFF, 9'd0}},
        '{REQ_PUSH_TAIL, 1'b1, 32'h0000_0100, 1'b1, '{STAT_OK,        1'b0, 32'h0, 9'd1}},
        '{REQ_DELETE,    1'b1, 32'hFFFF_FF00, 1'b0, NO_CHECK},
        '{REQ_POP_HEAD,  1'b1, 32'h0000_0000, 1'b0, NO_CHECK}
    };

    // request mix per stream mode, in the order of OP_CODES
    localparam logic [2:0] OP_CODES [8] = '{
        REQ_PUSH_HEAD, REQ_PUSH_TAIL, REQ_POP_HEAD, REQ_POP_TAIL,
        REQ_DELETE, REQ_SEARCH, REQ_CLEAR, REQ_UNUSED
    };
    localparam int OP_WEIGHT [4][8] = '{
        '{18, 18, 12, 12, 15, 16, 4, 5},
        '{43, 43,  2,  2,  3,  5, 0, 2},
        '{15, 15,  8,  8, 20, 30, 0, 4},
        '{ 4,  4, 38, 38,  6,  7, 0, 3}
    };

    // values picked often so that duplicates and matches are common
    localparam logic [31:0] FEW_VALUES [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0041,
        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_00FF
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        req_type;
    logic              value_is_char;
    logic [31:0]       value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic              result_is_char;
    logic [31:0]       result_value;
    logic [IDX_W-1:0]  element_count;

    // model of the node pool
    logic [32:0]       pool_payload [POOL_SIZE];
    logic [IDX_W-1:0]  pool_next    [POOL_SIZE];
    logic [IDX_W-1:0]  pool_prev    [POOL_SIZE];
    logic [IDX_W-1:0]  list_head;
    logic [IDX_W-1:0]  list_tail;
    logic [IDX_W-1:0]  free_head;
    logic [IDX_W-1:0]  list_len;

    deque_result_t     expected_results [$];
    int                errors       = 0;
    int                results_seen = 0;
    int                items_sent   = 0;
    int                quiet_cycles = 0;
    bit                src_steady   = 1'b0;
    bit                sink_steady  = 1'b0;

    doubly_linked_list_deque_top #(
        .CAPACITY (POOL_SIZE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .value_is_char  (value_is_char),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_is_char (result_is_char),
        .result_value   (result_value),
        .element_count  (element_count)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // empty list, every node on the free chain in index order
    function automatic void pool_reset();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_payload[i] = '0;
            pool_prev[i]    = '0;
            pool_next[i]    = IDX_W'(i + 1);
        end
        list_head = NIL;
        list_tail = NIL;
        free_head = '0;
        list_len  = '0;
    endfunction

    // first node from the front holding the key, NIL if none
    function automatic logic [IDX_W-1:0] find_key(logic [32:0] key);
        logic [IDX_W-1:0] cur;
        int               steps;
        cur   = list_head;
        steps = 0;
        while (cur < NIL && steps < int'(list_len))
        begin
            if (pool_payload[cur[ADDR_W-1:0]] == key)
            begin
                return cur;
            end
            cur = pool_next[cur[ADDR_W-1:0]];
            steps++;
        end
        return NIL;
    endfunction

    // take a node out of the list and put it at the head of the free chain
    function automatic void unlink_node(logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] nx;
        logic [IDX_W-1:0] pv;
        nx = pool_next[n[ADDR_W-1:0]];
        pv = pool_prev[n[ADDR_W-1:0]];
        if (nx >= NIL || n == list_tail)
        begin
            nx = NIL;
        end
        if (pv >= NIL || n == list_head)
        begin
            pv = NIL;
        end
        if (pv < NIL)
        begin
            pool_next[pv[ADDR_W-1:0]] = nx;
        end
        else
        begin
            list_head = nx;
        end
        if (nx < NIL)
        begin
            pool_prev[nx[ADDR_W-1:0]] = pv;
        end
        else
        begin
            list_tail = pv;
        end
        pool_next[n[ADDR_W-1:0]] = free_head;
        free_head                = n;
        if (list_len > 0)
        begin
            list_len--;
        end
    endfunction

    // apply one request to the pool model and return the result it gives
    function automatic deque_result_t apply_request(logic [2:0] req, logic is_char,
                                                    logic [31:0] val);
        deque_result_t    res;
        logic [32:0]      key;
        logic [IDX_W-1:0] n;
        res = '0;
        res.status = STAT_OK;
        key = is_char ? {1'b1, 24'h0, val[7:0]} : {1'b0, val};
        case (req)
            REQ_PUSH_HEAD, REQ_PUSH_TAIL:
            begin
                n = free_head;
                if (n >= NIL || list_len >= NIL)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    free_head                   = pool_next[n[ADDR_W-1:0]];
                    pool_payload[n[ADDR_W-1:0]] = key;
                    if (list_head >= NIL || list_len == 0)
                    begin
                        pool_next[n[ADDR_W-1:0]] = NIL;
                        pool_prev[n[ADDR_W-1:0]] = NIL;
                        list_head                = n;
                        list_tail                = n;
                    end
                    else if (req == REQ_PUSH_HEAD)
                    begin
                        pool_next[n[ADDR_W-1:0]]         = list_head;
                        pool_prev[n[ADDR_W-1:0]]         = NIL;
                        pool_prev[list_head[ADDR_W-1:0]] = n;
                        list_head                        = n;
                    end
                    else
                    begin
                        pool_next[n[ADDR_W-1:0]] = NIL;
                        pool_prev[n[ADDR_W-1:0]] = list_tail;
                        if (list_tail < NIL)
                        begin
                            pool_next[list_tail[ADDR_W-1:0]] = n;
                        end
                        list_tail = n;
                    end
                    list_len++;
                end
            end
            REQ_POP_HEAD, REQ_POP_TAIL:
            begin
                n = (req == REQ_POP_HEAD) ? list_head : list_tail;
                if (list_len == 0 || n >= NIL)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    res.is_char = pool_payload[n[ADDR_W-1:0]][32];
                    res.value   = pool_payload[n[ADDR_W-1:0]][31:0];
                    unlink_node(n);
                end
            end
            REQ_DELETE:
            begin
                if (list_len == 0 || list_head >= NIL)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    n = find_key(key);
                    if (n >= NIL)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        unlink_node(n);
                    end
                end
            end
            REQ_SEARCH:
            begin
                res.status = (find_key(key) < NIL) ? STAT_OK : STAT_NOT_FOUND;
            end
            REQ_CLEAR:
            begin
                // whole list goes onto the free chain in one splice
                if (list_len > 0 && list_head < NIL && list_tail < NIL)
                begin
                    pool_next[list_tail[ADDR_W-1:0]] = free_head;
                    free_head                        = list_head;
                end
                list_head = NIL;
                list_tail = NIL;
                list_len  = '0;
            end
            default:
            begin
            end
        endcase
        res.count = list_len;
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // offer one request item, wait for it to be taken, record its result
    task automatic send_request(logic [2:0] req, logic is_char, logic [31:0] val,
                                logic typed, deque_result_t want);
        int            gap;
        deque_result_t predicted;
        if (items_sent % 40 == 0)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
        end
        gap = src_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        value_is_char <= is_char;
        value         <= val;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        predicted = apply_request(req, is_char, val);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // draw one request; delete and search often aim at a stored element
    task automatic send_random(stream_mode_t mode);
        int               roll;
        int               acc;
        int               i;
        int               k;
        logic [2:0]       req;
        logic             is_char;
        logic [31:0]      val;
        logic [IDX_W-1:0] node;
        roll = $urandom_range(0, 99);
        acc  = 0;
        req  = REQ_UNUSED;
        for (i = 0; i < 8; i++)
        begin
            acc += OP_WEIGHT[mode][i];
            if (roll < acc)
            begin
                req = OP_CODES[i];
                break;
            end
        end
        roll    = $urandom_range(0, 99);
        is_char = 1'($urandom_range(0, 1));
        if ((req == REQ_DELETE || req == REQ_SEARCH) && list_len > 0 && roll < 55)
        begin
            k    = $urandom_range(0, int'(list_len) - 1);
            node = list_head;
            repeat (k) node = pool_next[node[ADDR_W-1:0]];
            is_char = pool_payload[node[ADDR_W-1:0]][32];
            val     = pool_payload[node[ADDR_W-1:0]][31:0];
        end
        else if (roll < 80)
        begin
            val = FEW_VALUES[$urandom_range(0, 7)];
        end
        else
        begin
            val = $urandom();
        end
        // a character keeps only its low byte, so fill the rest with noise
        if (is_char)
        begin
            val = ($urandom() & 32'hFFFF_FF00) | {24'h0, val[7:0]};
        end
        send_request(req, is_char, val, 1'b0, NO_CHECK);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_result
        deque_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result item with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (result_is_char !== want.is_char)
                begin
                    $error("result_is_char: expected %0d, got %0d", want.is_char,
                           result_is_char);
                    errors++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %h, got %h", want.value, result_value);
                    errors++;
                end
                if (element_count !== want.count)
                begin
                    $error("element_count: expected %0d, got %0d", want.count,
                           element_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls, two long hold-offs to back the block up
    initial
    begin
        int stall;
        int cyc;
        int holds_done;
        stall      = 0;
        cyc        = 0;
        holds_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0)
            begin
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if (holds_done < 2 && results_seen >= (holds_done == 0 ? 60 : 420))
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(negedge clk);
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = sink_steady ? 0 : idle_len();
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int random_sent;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_PUSH_HEAD;
        value_is_char = 1'b0;
        value         = '0;
        pool_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        foreach (DIRECTED[i])
        begin
            send_request(DIRECTED[i].req, DIRECTED[i].is_char, DIRECTED[i].value,
                         DIRECTED[i].typed, DIRECTED[i].want);
        end

        // random: mixed, fill the pool and push past full, churn while full,
        // drain past empty, then mixed again
        random_sent = items_sent;
        repeat (110) send_random(MODE_MIX);
        while (list_len < NIL)
        begin
            send_random(MODE_GROW);
        end
        repeat (12) send_random(MODE_GROW);
        repeat (60) send_random(MODE_FULL);
        while (list_len > 0)
        begin
            send_random(MODE_SHRINK);
        end
        repeat (10) send_random(MODE_SHRINK);
        while (items_sent - random_sent < RANDOM_ITEMS)
        begin
            send_random(MODE_MIX);
        end
        in_valid <= 1'b0;

        // wait for outstanding results, then watch for strays
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
